// File: sv/lxl_pkg.sv
// lxl_pkg: shared types and constants for the xyz to lab convert unit
// no dependencies; used by lxl_chan and xyz_to_lab_convert_unit
`default_nettype none
package lxl_pkg;

  localparam int TriWidth  = 24;   // q8.16 tristimulus
  localparam int DivSteps  = 32;   // quotient bits of the ratio divider
  localparam int CbrtBits  = 21;   // q.19 f value, up to cbrt(16)
  localparam int DivWidth  = 37;   // divisor up to 3132 * (2^24 - 1)
  localparam int NumWidth  = 59;   // linear dividend (24389x + 432w) << 19
  localparam int RemInit   = NumWidth - DivSteps;
  localparam int ChanLat   = 1 + DivSteps + CbrtBits;
  localparam int PipeLat   = ChanLat + 2;

  localparam logic [TriWidth-1:0] WhiteXRst = 24'd6229000;
  localparam logic [TriWidth-1:0] WhiteYRst = 24'd6553600;
  localparam logic [TriWidth-1:0] WhiteZRst = 24'd7135756;

  localparam logic [14:0] LightMax = 15'd18000;

  typedef enum logic [1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Y = 2'd1,
    REG_WHITE_Z = 2'd2
  } reg_idx_e;

endpackage
`default_nettype wire

// File: sv/lxl_chan.sv
// lxl_chan: one component of the conversion, ratio divide then f() via cube root
// depends on lxl_pkg; 1 prep stage, 32 divide stages, 21 cube root stages
`default_nettype none
module lxl_chan
  import lxl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [TriWidth-1:0] x_i,
  input  wire logic [TriWidth-1:0] w_i,
  output logic      [CbrtBits-1:0] f_o,
  output logic                     sat_o
);

  // prep stage
  logic [TriWidth-1:0] wz;
  logic                sat_d, cube_d;
  logic [39:0]         lin_num;
  logic [NumWidth-1:0] num_d;
  logic [DivWidth-1:0] div_d;

  always_comb begin
    wz      = (w_i == '0) ? TriWidth'(1) : w_i;
    sat_d   = {4'b0, x_i} > {wz, 4'b0};
    cube_d  = (40'(x_i) * 40'd24389) > (40'(wz) * 40'd216);
    lin_num = 40'(x_i) * 40'd24389 + 40'(wz) * 40'd432;
    if (cube_d) begin
      num_d = NumWidth'({x_i, 27'b0});
      div_d = DivWidth'(wz);
    end else begin
      num_d = {lin_num, 19'b0};
      div_d = DivWidth'(40'(wz) * 40'd3132);
    end
  end

  logic [DivWidth-1:0] rem_q  [0:DivSteps];
  logic [DivWidth-1:0] dvs_q  [0:DivSteps];
  logic [DivSteps-1:0] lo_q   [0:DivSteps];
  logic                cube_q [0:DivSteps];
  logic                sat_q  [0:DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DivWidth'(num_d[NumWidth-1:DivSteps]);
      lo_q[0]   <= num_d[DivSteps-1:0];
      dvs_q[0]  <= div_d;
      cube_q[0] <= cube_d;
      sat_q[0]  <= sat_d;
    end
  end

  // restoring divider, one quotient bit per stage shifted into lo
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [DivWidth:0] t;
    logic              ge;
    always_comb begin
      t  = {rem_q[i], lo_q[i][DivSteps-1]};
      ge = t >= {1'b0, dvs_q[i]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? DivWidth'(t - {1'b0, dvs_q[i]}) : t[DivWidth-1:0];
        lo_q[i+1]   <= {lo_q[i][DivSteps-2:0], ge};
        dvs_q[i+1]  <= dvs_q[i];
        cube_q[i+1] <= cube_q[i];
        sat_q[i+1]  <= sat_q[i];
      end
    end
  end

  // cube root, one result bit per stage, cube and square kept by shift-add
  logic [61:0]         cv_q  [1:CbrtBits];
  logic [CbrtBits-1:0] cy_q  [1:CbrtBits];
  logic [41:0]         cy2_q [1:CbrtBits];
  logic [63:0]         cy3_q [1:CbrtBits];
  logic [CbrtBits-1:0] lin_q [1:CbrtBits];
  logic                sel_q [1:CbrtBits];
  logic                cs_q  [1:CbrtBits];

  for (genvar j = 0; j < CbrtBits; j++) begin : g_cbrt
    localparam int K = CbrtBits - 1 - j;
    logic [61:0]         v_in;
    logic [CbrtBits-1:0] y_in, lin_in, c;
    logic [41:0]         y2_in, c2;
    logic [63:0]         y3_in, c3;
    logic                sel_in, s_in, take;
    if (j == 0) begin : g_first
      always_comb begin
        v_in   = {(sat_q[DivSteps] ? 32'h8000_0000 : lo_q[DivSteps]), 30'b0};
        y_in   = '0;
        y2_in  = '0;
        y3_in  = '0;
        lin_in = lo_q[DivSteps][CbrtBits-1:0];
        sel_in = cube_q[DivSteps] | sat_q[DivSteps];
        s_in   = sat_q[DivSteps];
      end
    end else begin : g_next
      always_comb begin
        v_in   = cv_q[j];
        y_in   = cy_q[j];
        y2_in  = cy2_q[j];
        y3_in  = cy3_q[j];
        lin_in = lin_q[j];
        sel_in = sel_q[j];
        s_in   = cs_q[j];
      end
    end
    always_comb begin
      c    = y_in | (CbrtBits'(1) << K);
      c2   = y2_in + (42'(y_in) << (K + 1)) + (42'(1) << (2 * K));
      c3   = y3_in + ((64'(y2_in) + (64'(y2_in) << 1)) << K)
             + ((64'(y_in) + (64'(y_in) << 1)) << (2 * K)) + (64'(1) << (3 * K));
      take = c3 <= 64'(v_in);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cv_q[j+1]  <= v_in;
        cy_q[j+1]  <= take ? c : y_in;
        cy2_q[j+1] <= take ? c2 : y2_in;
        cy3_q[j+1] <= take ? c3 : y3_in;
        lin_q[j+1] <= lin_in;
        sel_q[j+1] <= sel_in;
        cs_q[j+1]  <= s_in;
      end
    end
  end

  assign f_o   = sel_q[CbrtBits] ? cy_q[CbrtBits] : lin_q[CbrtBits];
  assign sat_o = cs_q[CbrtBits];

endmodule
`default_nettype wire

// File: sv/xyz_to_lab_convert_unit.sv
// xyz_to_lab_convert_unit: top level, white point registers, lab output math
// depends on lxl_pkg and lxl_chan
//
// usage: one xyz word (unsigned q8.16 per component) enters on in_valid_i
// when in_stall_o is low; one lab word leaves on out_valid_o, taken when
// out_stall_i is low. white point registers must be written through
// cfg_we_i, cfg_idx_i and cfg_data_i only while no word is in flight;
// this is not enforced. index 3 is ignored. the pipe is 1 prep stage,
// 32 stages of the ratio divider (one quotient bit each), 21 stages of
// the cube root (one bit each), one scale stage and the output register
// after round/clamp. throughput is one word per cycle when not stalled.
// the whole pipe advances together; when the output word is stalled every
// stage holds and in_stall_o rises, so nothing is lost or repeated. reset
// clears all valid bits and loads the d65 white point (y scaled to 100).
`default_nettype none
module xyz_to_lab_convert_unit
  import lxl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [TriWidth-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [TriWidth-1:0] x_tristim_i,
  input  wire logic [TriWidth-1:0] y_tristim_i,
  input  wire logic [TriWidth-1:0] z_tristim_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [14:0]              lightness_o,
  output logic signed [17:0]       green_red_o,
  output logic signed [15:0]       blue_yellow_o,
  output logic                     clamped_o
);

  logic [TriWidth-1:0] white_x_q, white_y_q, white_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= WhiteXRst;
      white_y_q <= WhiteYRst;
      white_z_q <= WhiteZRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WHITE_X: white_x_q <= cfg_data_i;
        REG_WHITE_Y: white_y_q <= cfg_data_i;
        REG_WHITE_Z: white_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic vld_q [0:PipeLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeLat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PipeLat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  logic [CbrtBits-1:0] fx, fy, fz;
  logic                sx, sy, sz;

  lxl_chan u_chan_x (.clk_i, .en_i(en), .x_i(x_tristim_i), .w_i(white_x_q),
                     .f_o(fx), .sat_o(sx));
  lxl_chan u_chan_y (.clk_i, .en_i(en), .x_i(y_tristim_i), .w_i(white_y_q),
                     .f_o(fy), .sat_o(sy));
  lxl_chan u_chan_z (.clk_i, .en_i(en), .x_i(z_tristim_i), .w_i(white_z_q),
                     .f_o(fz), .sat_o(sz));

  // scale stage
  logic signed [32:0] l1_d, a1_d, b1_d, l1_q, a1_q, b1_q;
  logic               sat1_q;

  always_comb begin
    l1_d = $signed(33'(fy)) * 33'sd116 - 33'sd8388608;
    a1_d = ($signed(33'(fx)) - $signed(33'(fy))) * 33'sd500;
    b1_d = ($signed(33'(fy)) - $signed(33'(fz))) * 33'sd200;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_q   <= l1_d;
      a1_q   <= a1_d;
      b1_q   <= b1_d;
      sat1_q <= sx | sy | sz;
    end
  end

  // round to 1/64, ties up
  logic signed [32:0] lr, ar, br;
  logic [14:0]        light_d;

  always_comb begin
    lr = (l1_q + 33'sd4096) >>> 13;
    ar = (a1_q + 33'sd4096) >>> 13;
    br = (b1_q + 33'sd4096) >>> 13;
    if (lr < 0) begin
      light_d = '0;
    end else if (lr > $signed(33'(LightMax))) begin
      light_d = LightMax;
    end else begin
      light_d = lr[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lightness_o   <= light_d;
      green_red_o   <= ar[17:0];
      blue_yellow_o <= br[15:0];
      clamped_o     <= sat1_q;
    end
  end

  assign out_valid_o = vld_q[PipeLat-1];

  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lightness_o <= LightMax)
    else $error("lightness out of range");

  a_valid_follows_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[PipeLat-2]))
    else $error("output word without a word in the last stage");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q[0]) && $stable(vld_q[PipeLat-2]))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
